// ----- sv/pixel_to_occupancy_cell_core_defines.svh -----
// ---------------------------------------------------------------------------
// Pixel to occupancy cell: assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PIXEL_TO_OCCUPANCY_CELL_CORE_DEFINES_SVH
`define PIXEL_TO_OCCUPANCY_CELL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked assertion, disabled while reset is low
`define P2OC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion that holds through reset as well
`define P2OC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define P2OC_ASSERT(lbl, clk, rst_n, prop, msg)
`define P2OC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/p2oc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel to occupancy cell: package
// Widths, register indexes, cell codes and shared word types.
// ---------------------------------------------------------------------------
package p2oc_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MAX_CHANNELS = 4;

    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 24;
    localparam int VAL_W   = 8;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 3;
    localparam int LEVEL_W = 17;
    localparam int DIM_W   = 13;
    localparam int SUM_W   = 10;              // up to 4 * 255
    localparam int PROD_W  = LEVEL_W + SUM_W; // level * scale
    localparam int LHS_W   = SUM_W + 16;      // dark * 65536
    localparam int QUOT_W  = 7;               // scaled value 0..99
    localparam int REM_W   = PROD_W + QUOT_W; // 99 * numerator

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LEVEL_W;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEGATE_COLORS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OCCUPIED_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_LEVEL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 3'd7;

    // map_mode codes; the unused code behaves as scaled
    localparam logic [MODE_W-1:0] MODE_TRINARY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCALED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAW     = 2'd2;

    // cell value codes
    localparam logic [VAL_W-1:0] VAL_FREE     = 8'd0;
    localparam logic [VAL_W-1:0] VAL_OCCUPIED = 8'd100;
    localparam logic [VAL_W-1:0] VAL_UNKNOWN  = 8'd255;

    localparam logic [QUOT_W-1:0] SCALE_SPAN = 7'd99;
    localparam logic [20:0]       RECIP_3    = 21'd683; // (2048 + 1) / 3

    // reset values
    localparam logic [CNT_W-1:0]   RST_CHANNEL_COUNT  = 3'd1;
    localparam logic [LEVEL_W-1:0] RST_OCCUPIED_LEVEL = 17'd42598;
    localparam logic [LEVEL_W-1:0] RST_FREE_LEVEL     = 17'd12845;
    localparam logic [DIM_W-1:0]   RST_MAP_DIM        = 13'd4096;

    localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);
    localparam logic [CNT_W-1:0] CHAN_LIMIT   = CNT_W'(MAX_CHANNELS);

    // settled configuration, counts and sizes already clamped
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               negate;
        logic [CNT_W-1:0]   chan_n;
        logic               has_alpha;
        logic [LEVEL_W-1:0] occ_level;
        logic [LEVEL_W-1:0] free_level;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } cfg_t;

    // word handed from the front stages to the divider
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
        logic              need_div;
        logic [REM_W-1:0]  rem;
        logic [PROD_W-1:0] den;
    } div_word_t;

endpackage

// ----- sv/p2oc_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel to occupancy cell: stream interfaces
// Valid/ready channels for pixel words and cell words.
// ---------------------------------------------------------------------------
interface p2oc_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [p2oc_pkg::COORD_W-1:0]   pixel_col;
    logic [p2oc_pkg::COORD_W-1:0]   pixel_row;
    logic [p2oc_pkg::CHAN_W-1:0]    chan0;
    logic [p2oc_pkg::CHAN_W-1:0]    chan1;
    logic [p2oc_pkg::CHAN_W-1:0]    chan2;
    logic [p2oc_pkg::CHAN_W-1:0]    chan3;

    modport source (output valid, pixel_col, pixel_row, chan0, chan1, chan2, chan3,
                    input ready);
    modport sink   (input valid, pixel_col, pixel_row, chan0, chan1, chan2, chan3,
                    output ready);
endinterface

interface p2oc_cell_if;
    logic                         valid;
    logic                         ready;
    logic [p2oc_pkg::IDX_W-1:0]   cell_index;
    logic [p2oc_pkg::VAL_W-1:0]   cell_value;

    modport source (output valid, cell_index, cell_value, input ready);
    modport sink   (input valid, cell_index, cell_value, output ready);
endinterface

// ----- sv/p2oc_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel to occupancy cell: front stages
// Four stages: average terms, products, classify, numerator scaling.
// ---------------------------------------------------------------------------
module p2oc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  p2oc_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [p2oc_pkg::COORD_W-1:0]  pixel_col,
    input  logic [p2oc_pkg::COORD_W-1:0]  pixel_row,
    input  logic [p2oc_pkg::CHAN_W-1:0]   chan0,
    input  logic [p2oc_pkg::CHAN_W-1:0]   chan1,
    input  logic [p2oc_pkg::CHAN_W-1:0]   chan2,
    input  logic [p2oc_pkg::CHAN_W-1:0]   chan3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output p2oc_pkg::div_word_t           out_word
);

    typedef struct packed {
        logic [p2oc_pkg::COORD_W-1:0] col;
        logic [p2oc_pkg::IDX_W-1:0]   flip;
        logic [p2oc_pkg::CNT_W-1:0]   navg;
        logic [p2oc_pkg::SUM_W-1:0]   bright;
        logic [p2oc_pkg::SUM_W-1:0]   dark;
        logic [p2oc_pkg::SUM_W-1:0]   scale;
        logic                         last_zero;
    } s1_t;

    typedef struct packed {
        logic [p2oc_pkg::COORD_W-1:0] col;
        logic [p2oc_pkg::IDX_W-1:0]   idx_prod;
        logic [p2oc_pkg::LHS_W-1:0]   lhs;
        logic [p2oc_pkg::PROD_W-1:0]  occ_prod;
        logic [p2oc_pkg::PROD_W-1:0]  free_prod;
        logic [p2oc_pkg::SUM_W-1:0]   scale;
        logic [p2oc_pkg::VAL_W-1:0]   raw_val;
        logic                         last_zero;
    } s2_t;

    typedef struct packed {
        logic [p2oc_pkg::IDX_W-1:0]   index;
        logic [p2oc_pkg::VAL_W-1:0]   value;
        logic                         need_div;
        logic [p2oc_pkg::PROD_W-1:0]  num;
        logic [p2oc_pkg::PROD_W-1:0]  den;
    } s3_t;

    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic      s1_en, s2_en, s3_en, s4_en;
    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    s3_t       s3_reg, s3_next;
    p2oc_pkg::div_word_t s4_reg, s4_next;

    logic                          trinary;
    logic                          raw_mode;
    logic [p2oc_pkg::CNT_W-1:0]    navg;
    logic [p2oc_pkg::SUM_W-1:0]    sum;
    logic [p2oc_pkg::SUM_W:0]      scale_w;
    logic [p2oc_pkg::CHAN_W-1:0]   last_chan;
    logic [36:0]                   idx_full;
    logic [20:0]                   third;
    logic                          gt_occ;
    logic                          lt_free;
    logic                          gap_pos;
    logic [p2oc_pkg::LEVEL_W-1:0]  gap;

    assign trinary  = (cfg.mode == p2oc_pkg::MODE_TRINARY);
    assign raw_mode = (cfg.mode == p2oc_pkg::MODE_RAW);

    // stall chain: a stage loads when empty or when its successor loads
    assign s4_en    = !s4_valid_reg || out_ready;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    // stage 1: channel sum, brightness, darkness, flipped row
    always_comb
    begin
        navg = (trinary || !cfg.has_alpha) ? cfg.chan_n : cfg.chan_n - 3'd1;
        if (navg == 3'd0)
        begin
            navg = cfg.chan_n;
        end
        sum = p2oc_pkg::SUM_W'(chan0)
            + ((navg >= 3'd2) ? p2oc_pkg::SUM_W'(chan1) : '0)
            + ((navg >= 3'd3) ? p2oc_pkg::SUM_W'(chan2) : '0)
            + ((navg >= 3'd4) ? p2oc_pkg::SUM_W'(chan3) : '0);
        scale_w = {navg, 8'b0} - (p2oc_pkg::SUM_W + 1)'(navg);
        case (cfg.chan_n)
            3'd2:    last_chan = chan1;
            3'd3:    last_chan = chan2;
            3'd4:    last_chan = chan3;
            default: last_chan = chan0;
        endcase
        s1_next.col       = pixel_col;
        s1_next.flip      = p2oc_pkg::IDX_W'(cfg.height) - p2oc_pkg::IDX_W'(1)
                          - p2oc_pkg::IDX_W'(pixel_row);
        s1_next.navg      = navg;
        s1_next.scale     = scale_w[p2oc_pkg::SUM_W-1:0];
        s1_next.bright    = cfg.negate ? scale_w[p2oc_pkg::SUM_W-1:0] - sum : sum;
        s1_next.dark      = scale_w[p2oc_pkg::SUM_W-1:0] - s1_next.bright;
        s1_next.last_zero = (cfg.chan_n > 3'd1) && (last_chan == '0);
    end

    // stage 2: index product, threshold products, raw average
    always_comb
    begin
        idx_full = 37'(cfg.width) * 37'(s1_reg.flip);
        third    = 21'(s1_reg.bright) * p2oc_pkg::RECIP_3;
        s2_next.col       = s1_reg.col;
        s2_next.idx_prod  = idx_full[p2oc_pkg::IDX_W-1:0];
        s2_next.lhs       = {s1_reg.dark, 16'b0};
        s2_next.occ_prod  = p2oc_pkg::PROD_W'(cfg.occ_level) * p2oc_pkg::PROD_W'(s1_reg.scale);
        s2_next.free_prod = p2oc_pkg::PROD_W'(cfg.free_level) * p2oc_pkg::PROD_W'(s1_reg.scale);
        s2_next.scale     = s1_reg.scale;
        s2_next.last_zero = s1_reg.last_zero;
        case (s1_reg.navg)
            3'd2:    s2_next.raw_val = s1_reg.bright[8:1];
            3'd3:    s2_next.raw_val = third[18:11];
            3'd4:    s2_next.raw_val = s1_reg.bright[9:2];
            default: s2_next.raw_val = s1_reg.bright[7:0];
        endcase
    end

    // stage 3: exact rational compares, fixed codes, divider operands
    always_comb
    begin
        gt_occ  = p2oc_pkg::PROD_W'(s2_reg.lhs) > s2_reg.occ_prod;
        lt_free = p2oc_pkg::PROD_W'(s2_reg.lhs) < s2_reg.free_prod;
        gap_pos = cfg.occ_level > cfg.free_level;
        gap     = cfg.occ_level - cfg.free_level;
        s3_next.index    = s2_reg.idx_prod + p2oc_pkg::IDX_W'(s2_reg.col);
        s3_next.num      = p2oc_pkg::PROD_W'(s2_reg.lhs) - s2_reg.free_prod;
        s3_next.den      = p2oc_pkg::PROD_W'(s2_reg.scale) * p2oc_pkg::PROD_W'(gap);
        s3_next.need_div = 1'b0;
        if (raw_mode)
        begin
            s3_next.value = s2_reg.raw_val;
        end
        else if (gt_occ)
        begin
            s3_next.value = p2oc_pkg::VAL_OCCUPIED;
        end
        else if (lt_free)
        begin
            s3_next.value = p2oc_pkg::VAL_FREE;
        end
        else if (trinary || s2_reg.last_zero)
        begin
            s3_next.value = p2oc_pkg::VAL_UNKNOWN;
        end
        else if (!gap_pos)
        begin
            s3_next.value = p2oc_pkg::VAL_FREE;
        end
        else
        begin
            s3_next.value    = '0;
            s3_next.need_div = 1'b1;
        end
    end

    // stage 4: dividend = 99 * numerator
    always_comb
    begin
        s4_next.index    = s3_reg.index;
        s4_next.value    = s3_reg.value;
        s4_next.need_div = s3_reg.need_div;
        s4_next.rem      = p2oc_pkg::REM_W'(s3_reg.num) * p2oc_pkg::REM_W'(p2oc_pkg::SCALE_SPAN);
        s4_next.den      = s3_reg.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en) s1_valid_reg <= in_valid;
            if (s2_en) s2_valid_reg <= s1_valid_reg;
            if (s3_en) s3_valid_reg <= s2_valid_reg;
            if (s4_en) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en) s1_reg <= s1_next;
        if (s2_en) s2_reg <= s2_next;
        if (s3_en) s3_reg <= s3_next;
        if (s4_en) s4_reg <= s4_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_word  = s4_reg;

endmodule

// ----- sv/p2oc_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel to occupancy cell: quotient pipeline
// Restoring division, one quotient bit per stage, for the scaled value.
// ---------------------------------------------------------------------------
module p2oc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  p2oc_pkg::div_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output p2oc_pkg::div_word_t  out_word
);

    localparam int STEPS = p2oc_pkg::QUOT_W;

    logic                valid_reg [STEPS];
    p2oc_pkg::div_word_t word_reg  [STEPS];
    p2oc_pkg::div_word_t word_next [STEPS];
    logic                en        [STEPS];

    always_comb
    begin
        en[STEPS-1] = !valid_reg[STEPS-1] || out_ready;
        for (int i = STEPS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam int K = STEPS - 1 - i;
        p2oc_pkg::div_word_t      src;
        logic                     src_valid;
        logic [p2oc_pkg::REM_W-1:0] trial;

        if (i == 0)
        begin : g_first
            assign src       = in_word;
            assign src_valid = in_valid;
        end
        else
        begin : g_rest
            assign src       = word_reg[i-1];
            assign src_valid = valid_reg[i-1];
        end

        always_comb
        begin
            trial        = p2oc_pkg::REM_W'(src.den) << K;
            word_next[i] = src;
            if (src.need_div && (src.rem >= trial))
            begin
                word_next[i].rem      = src.rem - trial;
                word_next[i].value[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en[i])
            begin
                valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                word_reg[i] <= word_next[i];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_word  = word_reg[STEPS-1];

endmodule

// ----- sv/pixel_to_occupancy_cell_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel to occupancy cell: top level
// Turns one image pixel word into one occupancy map cell word.
// ---------------------------------------------------------------------------
// Usage:
//   pixel (sink): one word per pixel, column, row (0 = top) and four channel
//     bytes; unused channel bytes are ignored.
//   map_cell (source): cell_index = width * (height - 1 - row) + col (mod 2^24),
//     cell_value = raw average, or 100 / 0 / 255 (unknown) / floor(99 * ratio).
//   cfg_we / cfg_idx / cfg_data: register write, taken on any edge with
//     cfg_we high. Write only while no pixel word is in flight.
// Depth: 4 front stages, 7 quotient stages and 1 output register lie between
//   pixel accept and cell valid. Throughput: one word per cycle while
//   map_cell.ready stays high. The 7-bit quotient of the scaled value is
//   built one bit per stage, so the divider depth sets the latency, not rate.
// Reset: all stages empty, registers at their documented defaults.
// Stall: each stage loads whenever it is empty or its successor moves, so
//   bubbles fill up behind a stalled output and new pixels keep entering until
//   every stage holds a word; then pixel.ready drops. Nothing is lost or
//   repeated.
// ---------------------------------------------------------------------------
`include "pixel_to_occupancy_cell_core_defines.svh"

module pixel_to_occupancy_cell_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [p2oc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [p2oc_pkg::CFG_DATA_W-1:0]  cfg_data,
    p2oc_pixel_if.sink                       pixel,
    p2oc_cell_if.source                      map_cell
);

    // configuration registers
    logic [p2oc_pkg::MODE_W-1:0]  map_mode_reg;
    logic                         negate_colors_reg;
    logic [p2oc_pkg::CNT_W-1:0]   channel_count_reg;
    logic                         has_alpha_reg;
    logic [p2oc_pkg::LEVEL_W-1:0] occupied_level_reg;
    logic [p2oc_pkg::LEVEL_W-1:0] free_level_reg;
    logic [p2oc_pkg::DIM_W-1:0]   map_width_reg;
    logic [p2oc_pkg::DIM_W-1:0]   map_height_reg;

    p2oc_pkg::cfg_t cfg;

    logic                front_valid, front_ready;
    p2oc_pkg::div_word_t front_word;
    logic                div_valid, div_ready;
    p2oc_pkg::div_word_t div_word;

    // output register
    logic                        cell_valid_reg;
    logic [p2oc_pkg::IDX_W-1:0]  cell_index_reg;
    logic [p2oc_pkg::VAL_W-1:0]  cell_value_reg;
    logic                        out_en;

    // output word classes checked below
    logic                        occ_out;
    logic                        occ_val;
    logic                        trinary_out;
    logic                        code_val;
    logic                        refill_due;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg       <= p2oc_pkg::MODE_TRINARY;
            negate_colors_reg  <= 1'b0;
            channel_count_reg  <= p2oc_pkg::RST_CHANNEL_COUNT;
            has_alpha_reg      <= 1'b0;
            occupied_level_reg <= p2oc_pkg::RST_OCCUPIED_LEVEL;
            free_level_reg     <= p2oc_pkg::RST_FREE_LEVEL;
            map_width_reg      <= p2oc_pkg::RST_MAP_DIM;
            map_height_reg     <= p2oc_pkg::RST_MAP_DIM;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                p2oc_pkg::REG_MAP_MODE:       map_mode_reg       <= cfg_data[1:0];
                p2oc_pkg::REG_NEGATE_COLORS:  negate_colors_reg  <= cfg_data[0];
                p2oc_pkg::REG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[2:0];
                p2oc_pkg::REG_HAS_ALPHA:      has_alpha_reg      <= cfg_data[0];
                p2oc_pkg::REG_OCCUPIED_LEVEL: occupied_level_reg <= cfg_data;
                p2oc_pkg::REG_FREE_LEVEL:     free_level_reg     <= cfg_data;
                p2oc_pkg::REG_MAP_WIDTH:      map_width_reg      <= cfg_data[12:0];
                p2oc_pkg::REG_MAP_HEIGHT:     map_height_reg     <= cfg_data[12:0];
                default:                      ;
            endcase
        end
    end

    // clamp: channel count 0 acts as 1, oversize values saturate
    always_comb
    begin
        cfg.mode       = map_mode_reg;
        cfg.negate     = negate_colors_reg;
        cfg.has_alpha  = has_alpha_reg;
        cfg.occ_level  = occupied_level_reg;
        cfg.free_level = free_level_reg;
        if (channel_count_reg == '0)
        begin
            cfg.chan_n = 3'd1;
        end
        else if (channel_count_reg > p2oc_pkg::CHAN_LIMIT)
        begin
            cfg.chan_n = p2oc_pkg::CHAN_LIMIT;
        end
        else
        begin
            cfg.chan_n = channel_count_reg;
        end
        cfg.width  = (map_width_reg > p2oc_pkg::WIDTH_LIMIT) ?
                     p2oc_pkg::WIDTH_LIMIT : map_width_reg;
        cfg.height = (map_height_reg > p2oc_pkg::HEIGHT_LIMIT) ?
                     p2oc_pkg::HEIGHT_LIMIT : map_height_reg;
    end

    p2oc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .pixel_col (pixel.pixel_col),
        .pixel_row (pixel.pixel_row),
        .chan0     (pixel.chan0),
        .chan1     (pixel.chan1),
        .chan2     (pixel.chan2),
        .chan3     (pixel.chan3),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_word  (front_word)
    );

    p2oc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_word   (front_word),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_word  (div_word)
    );

    // output register parts the pipeline from the cell receiver
    assign out_en    = !cell_valid_reg || map_cell.ready;
    assign div_ready = out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            cell_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            cell_index_reg <= div_word.index;
            cell_value_reg <= div_word.value;
        end
    end

    assign map_cell.valid      = cell_valid_reg;
    assign map_cell.cell_index = cell_index_reg;
    assign map_cell.cell_value = cell_value_reg;

    assign occ_out     = cell_valid_reg && (map_mode_reg != p2oc_pkg::MODE_RAW);
    assign occ_val     = (cell_value_reg <= p2oc_pkg::VAL_OCCUPIED)
                      || (cell_value_reg == p2oc_pkg::VAL_UNKNOWN);
    assign trinary_out = cell_valid_reg && (map_mode_reg == p2oc_pkg::MODE_TRINARY);
    assign code_val    = (cell_value_reg == p2oc_pkg::VAL_FREE)
                      || (cell_value_reg == p2oc_pkg::VAL_OCCUPIED)
                      || (cell_value_reg == p2oc_pkg::VAL_UNKNOWN);
    assign refill_due  = cell_valid_reg && map_cell.ready && div_valid;

    // occupancy modes never produce a value above 100 other than unknown
    `P2OC_ASSERT(a_occ_range, clk, rst_n, occ_out |-> occ_val, "cell value out of occupancy range")
    // trinary mode gives only free, occupied or unknown
    `P2OC_ASSERT(a_trinary_codes, clk, rst_n, trinary_out |-> code_val, "not a trinary code")
    // a taken cell word with a word waiting behind it is refilled at once
    `P2OC_ASSERT(a_refill, clk, rst_n, refill_due |=> cell_valid_reg, "output not refilled")
    // an empty output register always accepts from the divider
    `P2OC_ASSERT_ALWAYS(a_empty_takes, clk, !cell_valid_reg |-> div_ready, "stall while output empty")

endmodule

// ----- dv/occupancy_cell_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Occupancy cell checker
// Snoops register writes and both streams, predicts each cell word from the
// pixel word that caused it and compares index and value in order.
// ---------------------------------------------------------------------------
module occupancy_cell_checker
    import p2oc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    p2oc_pixel_if                 pix,
    p2oc_cell_if                  cells,
    output int                    mismatches,
    output int                    cells_checked,
    output int                    cells_owed
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } cell_word_t;

    cell_word_t cells_due [$];
    cfg_t       regs;
    int         fail_tally;
    int         seen_tally;

    // raw register copy, clamping happens here
    function automatic cell_word_t occupancy_of(input cfg_t r,
                                                input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row,
                                                input logic [3:0][CHAN_W-1:0] ch);
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] navg;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] scale;
        logic [SUM_W-1:0] bright;
        logic [SUM_W-1:0] dark;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [IDX_W-1:0] flip;
        logic [63:0]      prod;
        logic [63:0]      lhs;
        logic [63:0]      occ_bar;
        logic [63:0]      free_bar;
        bit               trinary;
        cell_word_t       res;

        n = r.chan_n;
        if (n == 0)
            n = 1;
        if (n > CHAN_LIMIT)
            n = CHAN_LIMIT;
        trinary = (r.mode == MODE_TRINARY);
        navg = (trinary || !r.has_alpha) ? n : n - 1;
        if (navg == 0)
            navg = n;

        sum = '0;
        for (int i = 0; i < navg; i++)
            sum += SUM_W'(ch[i]);
        scale  = SUM_W'(255 * navg);
        bright = r.negate ? scale - sum : sum;

        w = (r.width > WIDTH_LIMIT) ? WIDTH_LIMIT : r.width;
        h = (r.height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : r.height;
        flip = IDX_W'(h) - IDX_W'(1) - IDX_W'(row);
        prod = 64'(w) * 64'(flip) + 64'(col);
        res.index = prod[IDX_W-1:0];

        if (r.mode == MODE_RAW)
        begin
            res.value = VAL_W'(bright / SUM_W'(navg));
        end
        else
        begin
            // darkness dark/scale against level/65536, cross-multiplied
            dark     = scale - bright;
            lhs      = 64'(dark) << 16;
            occ_bar  = 64'(r.occ_level) * 64'(scale);
            free_bar = 64'(r.free_level) * 64'(scale);
            if (lhs > occ_bar)
                res.value = VAL_OCCUPIED;
            else if (lhs < free_bar)
                res.value = VAL_FREE;
            else if (trinary || (n > 1 && ch[n-1] == 0))
                res.value = VAL_UNKNOWN;
            else if (r.occ_level <= r.free_level)
                res.value = VAL_FREE;
            else
                res.value = VAL_W'((64'd99 * (lhs - free_bar))
                                   / (64'(scale) * 64'(r.occ_level - r.free_level)));
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cell_word_t want;
        cell_word_t got;

        if (!rst_n)
        begin
            regs.mode       = MODE_TRINARY;
            regs.negate     = 1'b0;
            regs.chan_n     = RST_CHANNEL_COUNT;
            regs.has_alpha  = 1'b0;
            regs.occ_level  = RST_OCCUPIED_LEVEL;
            regs.free_level = RST_FREE_LEVEL;
            regs.width      = RST_MAP_DIM;
            regs.height     = RST_MAP_DIM;
            cells_due.delete();
        end
        else
        begin
            // results first: a pixel taken this edge cannot have its word out yet
            if (cells.valid && cells.ready)
            begin
                seen_tally++;
                got.index = cells.cell_index;
                got.value = cells.cell_value;
                if (cells_due.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= MAX_REPORTS)
                        $display("%0t: unexpected cell word index %0d value %0d",
                                 $realtime, got.index, got.value);
                end
                else
                begin
                    want = cells_due.pop_front();
                    if (got.index !== want.index || got.value !== want.value)
                    begin
                        fail_tally++;
                        if (fail_tally <= MAX_REPORTS)
                            $display("%0t: cell word differs: index exp %0d got %0d, value exp %0d got %0d",
                                     $realtime, want.index, got.index, want.value, got.value);
                    end
                end
            end

            if (pix.valid && pix.ready)
                cells_due.push_back(occupancy_of(regs, pix.pixel_col, pix.pixel_row,
                                                 {pix.chan3, pix.chan2, pix.chan1, pix.chan0}));

            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_MAP_MODE:       regs.mode       = cfg_data[MODE_W-1:0];
                    REG_NEGATE_COLORS:  regs.negate     = cfg_data[0];
                    REG_CHANNEL_COUNT:  regs.chan_n     = cfg_data[CNT_W-1:0];
                    REG_HAS_ALPHA:      regs.has_alpha  = cfg_data[0];
                    REG_OCCUPIED_LEVEL: regs.occ_level  = cfg_data[LEVEL_W-1:0];
                    REG_FREE_LEVEL:     regs.free_level = cfg_data[LEVEL_W-1:0];
                    REG_MAP_WIDTH:      regs.width      = cfg_data[DIM_W-1:0];
                    REG_MAP_HEIGHT:     regs.height     = cfg_data[DIM_W-1:0];
                    default:            ;
                endcase
            end
        end

        mismatches    <= fail_tally;
        cells_checked <= seen_tally;
        cells_owed    <= cells_due.size();
    end

endmodule

// ----- dv/tb_pixel_to_occupancy_cell_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel to occupancy cell: testbench top
// Drives pixel words and register settings into the core, takes cell words
// with random back-pressure, and leaves prediction and comparison to the
// checker beside the core. Directed corner words first, then random phases,
// each under its own register setting.
// ---------------------------------------------------------------------------
module tb_pixel_to_occupancy_cell_core;
    import p2oc_pkg::*;

    // Core latency from pixel accept to cell valid.
    localparam int LATENCY         = 12;
    // Cycles with no word moving on either stream before the run is called dead.
    // Longest correct quiet stretch is the receiver hold-off plus a setting load.
    localparam int STALL_LIMIT     = 2000;
    localparam int GAP_PCT         = 28;
    localparam int HOLD_CYCLES     = 80;
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 78;
    // phase that runs with no gaps at all and carries the receiver hold-off
    localparam int BURST_PHASE     = 4;

    // map_mode code the core leaves unassigned; acts as scaled
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0]      col;
        logic [COORD_W-1:0]      row;
        logic [3:0][CHAN_W-1:0]  chan;
    } pixel_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    p2oc_pixel_if pix_ch ();
    p2oc_cell_if  cell_ch ();

    int mismatches;
    int cells_checked;
    int cells_owed;
    int words_sent;
    int phases_run;

    // Flow control flags, written only by the stimulus process.
    bit no_gaps;
    bit hold_wanted;
    // Set only by the receiver once its hold-off is done.
    bit hold_done;

    // Port order: clk, rst_n, cfg_we, cfg_idx, cfg_data, pixel, cell.
    pixel_to_occupancy_cell_core u_dut (
        clk, rst_n, cfg_we, cfg_idx, cfg_data, pix_ch, cell_ch
    );

    occupancy_cell_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .pix           (pix_ch),
        .cells         (cell_ch),
        .mismatches    (mismatches),
        .cells_checked (cells_checked),
        .cells_owed    (cells_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One idle decision for either side; off during the burst phase.
    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < GAP_PCT);
    endfunction

    // Byte biased toward the two extremes; zero also hits the
    // "last channel is zero" unknown rule.
    function automatic logic [CHAN_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    // Mostly inside the map, sometimes anywhere in the 12-bit range so the
    // index wraps.
    function automatic logic [COORD_W-1:0] pick_coord(input logic [DIM_W-1:0] dim);
        int span;
        span = (int'(dim) > (1 << COORD_W)) ? (1 << COORD_W) : int'(dim);
        if (span == 0 || $urandom_range(3) == 0)
            return COORD_W'($urandom);
        return COORD_W'($urandom_range(span - 1));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(7))
            0:       return DIM_W'($urandom_range(8191, 4097));  // saturates in core
            1:       return RST_MAP_DIM;
            2:       return DIM_W'($urandom_range(4096, 1));
            3:       return DIM_W'($urandom_range(1));           // zero wraps flip
            default: return DIM_W'($urandom_range(64, 1));
        endcase
    endfunction

    function automatic cfg_t settings(input logic [MODE_W-1:0] mode,
                                      input logic negate,
                                      input logic [CNT_W-1:0] chan_n,
                                      input logic has_alpha,
                                      input int occ_level,
                                      input int free_level,
                                      input int width,
                                      input int height);
        cfg_t s;
        s.mode       = mode;
        s.negate     = negate;
        s.chan_n     = chan_n;
        s.has_alpha  = has_alpha;
        s.occ_level  = LEVEL_W'(occ_level);
        s.free_level = LEVEL_W'(free_level);
        s.width      = DIM_W'(width);
        s.height     = DIM_W'(height);
        return s;
    endfunction

    function automatic cfg_t random_settings();
        int t;
        int f;
        logic [CNT_W-1:0] n;

        // mostly legal channel counts; now and then 0 or 5..7
        n = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(7))
                                     : CNT_W'($urandom_range(4, 1));
        case ($urandom_range(9))
            0:       begin t = $urandom_range(65536); f = t; end        // zero gap
            1:       begin f = $urandom_range(65536, 1); t = $urandom_range(f - 1); end
            2:       begin t = $urandom_range(131071, 65537); f = $urandom_range(t); end
            3:       begin
                         t = $urandom_range(1) ? 65536 : 0;
                         f = $urandom_range(1) ? 0 : 65536;
                     end
            default: begin f = $urandom_range(40000); t = $urandom_range(65536, f + 1); end
        endcase
        return settings(MODE_W'($urandom_range(3)), 1'($urandom_range(1)), n,
                        1'($urandom_range(1)), t, f, pick_dim(), pick_dim());
    endfunction

    function automatic pixel_word_t random_pixel(input cfg_t s);
        pixel_word_t p;
        p.col = pick_coord(s.width);
        p.row = pick_coord(s.height);
        for (int i = 0; i < 4; i++)
            p.chan[i] = pick_byte();
        return p;
    endfunction

    // Offer one pixel word, maybe after a few idle cycles, and hold it until
    // taken. Valid stays high into the next word when no gap is drawn.
    task automatic send_pixel(input pixel_word_t p);
        while (take_gap())
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_col <= p.col;
        pix_ch.pixel_row <= p.row;
        pix_ch.chan0     <= p.chan[0];
        pix_ch.chan1     <= p.chan[1];
        pix_ch.chan2     <= p.chan[2];
        pix_ch.chan3     <= p.chan[3];
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_bytes(input int col, input int row,
                              input int c0, input int c1, input int c2, input int c3);
        pixel_word_t p;
        p.col     = COORD_W'(col);
        p.row     = COORD_W'(row);
        p.chan[0] = CHAN_W'(c0);
        p.chan[1] = CHAN_W'(c1);
        p.chan[2] = CHAN_W'(c2);
        p.chan[3] = CHAN_W'(c3);
        send_pixel(p);
    endtask

    // Stop offering and wait until every word sent has come back. Each pixel
    // makes exactly one cell word, so the core is empty at that point.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (cells_checked < words_sent)
            @(posedge clk);
    endtask

    // One register write. Bits above the register's width carry junk so that
    // the core's masking is exercised too. The caller lowers cfg_we.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value,
                             input int bits);
        logic [CFG_DATA_W-1:0] junk;
        junk = (bits >= CFG_DATA_W) ? '0 : CFG_DATA_W'($urandom) << bits;
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= junk | value;
        @(posedge clk);
    endtask

    // Every register is written on every setting change.
    task automatic load_settings(input cfg_t s);
        drain();
        write_reg(REG_MAP_MODE,       CFG_DATA_W'(s.mode),       MODE_W);
        write_reg(REG_NEGATE_COLORS,  CFG_DATA_W'(s.negate),     1);
        write_reg(REG_CHANNEL_COUNT,  CFG_DATA_W'(s.chan_n),     CNT_W);
        write_reg(REG_HAS_ALPHA,      CFG_DATA_W'(s.has_alpha),  1);
        write_reg(REG_OCCUPIED_LEVEL, CFG_DATA_W'(s.occ_level),  LEVEL_W);
        write_reg(REG_FREE_LEVEL,     CFG_DATA_W'(s.free_level), LEVEL_W);
        write_reg(REG_MAP_WIDTH,      CFG_DATA_W'(s.width),      DIM_W);
        write_reg(REG_MAP_HEIGHT,     CFG_DATA_W'(s.height),     DIM_W);
        cfg_we <= 1'b0;
        phases_run++;
    endtask

    // Directed corners, seventeen words.
    task automatic run_directed();
        // reset defaults: trinary, one channel, 4096 x 4096 map
        send_bytes(0, 0, 0, 0, 0, 0);              // black: occupied, top-left
        send_bytes(4095, 4095, 255, 255, 255, 255); // white: free, index at row 0
        send_bytes(17, 200, 128, 0, 0, 0);         // mid gray: unknown

        // scaled, three colour channels
        load_settings(settings(MODE_SCALED, 1'b0, 3'd3, 1'b0, 42598, 12845, 640, 480));
        send_bytes(5, 7, 120, 130, 140, 9);        // between thresholds: scaled
        send_bytes(5, 7, 150, 150, 0, 9);          // last channel byte zero: unknown
        send_bytes(639, 479, 255, 255, 255, 0);

        // raw average, negated, RGBA with alpha left out
        load_settings(settings(MODE_RAW, 1'b1, 3'd4, 1'b1, 42598, 12845, 4096, 4096));
        send_bytes(1, 2, 10, 20, 30, 0);
        send_bytes(4095, 0, 255, 255, 255, 255);
        send_bytes(0, 4095, 0, 0, 0, 255);

        // zero threshold gap: darkness lands exactly on t == f
        load_settings(settings(MODE_SCALED, 1'b0, 3'd2, 1'b0, 32768, 32768, 100, 100));
        send_bytes(3, 4, 0, 255, 0, 0);            // on the gap: 0
        send_bytes(3, 4, 255, 0, 0, 0);            // on the gap, last byte zero: unknown
        send_bytes(99, 99, 0, 0, 0, 0);

        // spare mode code, channel count 0 with alpha, thresholds past 1.0,
        // oversized width, zero height so the flipped row wraps
        load_settings(settings(MODE_SPARE, 1'b0, 3'd0, 1'b1, 131071, 0, 8191, 0));
        send_bytes(4095, 0, 0, 77, 77, 77);
        send_bytes(0, 4095, 77, 0, 0, 0);
        send_bytes(2048, 2048, 255, 1, 1, 1);

        // trinary with alpha counted, count 7 saturating to 4, 1 x 1 map,
        // coordinates far outside it
        load_settings(settings(MODE_TRINARY, 1'b1, 3'd7, 1'b1, 65536, 0, 1, 1));
        send_bytes(4095, 4095, 0, 0, 0, 0);
        send_bytes(0, 0, 255, 128, 64, 32);
    endtask

    // Receiver: random ready, plus one long hold-off while the sender keeps
    // offering, so every stage fills and pixel ready drops.
    initial
    begin : cell_taker
        cell_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_done)
            begin
                cell_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            cell_ch.ready <= !take_gap();
        end
    end

    // Watchdog: any word moving on either stream resets the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pix_ch.valid && pix_ch.ready) || (cell_ch.valid && cell_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Run stalled: %0d cycles without a word moving", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t s;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= REG_MAP_MODE;
        cfg_data         <= '0;
        pix_ch.valid     <= 1'b0;
        pix_ch.pixel_col <= '0;
        pix_ch.pixel_row <= '0;
        pix_ch.chan0     <= '0;
        pix_ch.chan1     <= '0;
        pix_ch.chan2     <= '0;
        pix_ch.chan3     <= '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random phases. The first two pin the low and high corners of the
        // register space; the rest draw settings at random.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                s = settings(MODE_TRINARY, 1'b0, 3'd1, 1'b0, 0, 0, 1, 1);
            else if (p == 1)
                s = settings(MODE_SPARE, 1'b1, 3'd7, 1'b1, 131071, 131071, 8191, 8191);
            else
                s = random_settings();
            load_settings(s);

            if (p == BURST_PHASE)
            begin
                no_gaps     = 1'b1;
                hold_wanted = 1'b1;
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++)
                send_pixel(random_pixel(s));
            no_gaps = 1'b0;
        end

        drain();
        // let any stray extra word show up before the verdict
        repeat (LATENCY + 8) @(posedge clk);

        $display("Covered %0d pixel words under %0d register settings, %0d cell words taken",
                 words_sent, phases_run + 1, cells_checked);
        if (cells_owed != 0)
            $display("%0d predicted cell words never arrived", cells_owed);
        if (mismatches == 0 && cells_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
